FILE: sv/ksi_pkg.sv
// shared types and constants of the keyframe servo interpolator
package ksi_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int FULL_SCALE_DEF = 180;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] REG_PERIOD    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_AMPLITUDE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DIRECTION = 3'd2;
  localparam logic [CFG_AW-1:0] REG_INIT0     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_INIT1     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_INIT2     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_KF_COUNT  = 3'd6;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] MOTOR_LEFT   = 2'd0;
  localparam logic [1:0] MOTOR_CENTRE = 2'd1;
  localparam logic [1:0] MOTOR_RIGHT  = 2'd2;

  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] amount;
    logic [15:0] start;
    logic [15:0] duration;
  } kf_t;

endpackage

FILE: sv/keyframe_servo_interpolator.sv
// keyframe servo interpolator: keyframe table, phase timer and serial interpolation
//
// Input stream (s_*): one transfer is a load or a tick, chosen by s_tuser.
// A load writes one keyframe slot and gives no result.
// A tick advances the phase timer by delta_us, wraps it once by the period,
// walks the keyframe table and gives one result transfer on m_* holding
// the three drive values. Configuration registers are written through
// cfg_we / cfg_addr / cfg_wdata; the user must write them only while the
// block is idle, as the block itself does not enforce it. The interpolated
// step of a keyframe whose window holds the timer is formed by the
// bit-serial multiplier and divider, one bit per cycle over 16 bits each.
// One item is worked on at a time; s_tready is high only when idle.
// The result sits in an output register: the next item is taken while it
// waits. When the receiver stalls and a second result is ready, the block
// holds that result and takes no item until the output register frees.
// Reset (rst, synchronous) clears the timer, loads the register defaults
// and empties the output; keyframe slots hold nothing until loaded.
module keyframe_servo_interpolator
  import ksi_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // frame_index, frame_motor, frame_amount, frame_start, frame_duration,
  // delta_us, zero pad
  input  logic [79:0]       s_tdata,
  // req_type
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // motor_left, motor_centre, motor_right
  output logic [23:0]       m_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam logic [7:0]  FS     = 8'(FULL_SCALE);
  localparam logic [39:0] FS_LIM = 40'(FULL_SCALE) << 29;

  typedef enum logic [3:0] {
    IDLE, T_ADD, T_WRAP, FETCH, LOOK, LOOK2, CMP, CHK,
    MUL, DIV, APPLY, D_SCALE, D_AMP, D_FS, D_SAT, DONE
  } state_t;

  state_t st;

  // input fields
  logic [2:0]  frame_index;
  logic [1:0]  frame_motor;
  logic [15:0] frame_amount, frame_start, frame_duration;
  logic [23:0] delta_us;

  assign frame_index    = s_tdata[2:0];
  assign frame_motor    = s_tdata[4:3];
  assign frame_amount   = s_tdata[20:5];
  assign frame_start    = s_tdata[36:21];
  assign frame_duration = s_tdata[52:37];
  assign delta_us       = s_tdata[76:53];

  // configuration
  logic [23:0] period_us;
  logic [15:0] amplitude, direction;
  logic [15:0] init_pos [3];
  logic [3:0]  keyframe_count;

  // keyframe memory
  kf_t mem [MAX_FRAMES];
  kf_t kf;

  // work registers
  logic [23:0] timer, delta;
  logic [24:0] tsum;
  logic [15:0] prev [3];
  logic [15:0] pos [3];
  logic [CW-1:0] wi;
  logic [39:0] s_val, d_val, n_val;
  logic        ge;
  logic [15:0] dif, mb, quo;
  logic        up;
  logic [3:0]  bc;
  logic [55:0] acc, dsh;
  logic [1:0]  mi;
  logic [15:0] sp;
  logic [31:0] pa;
  logic [39:0] pf;
  logic [7:0]  drv [3];

  logic          accept, ld;
  logic [CW-1:0] limit, wi_next;
  logic          last_frame;
  logic [39:0]   tq;
  logic [15:0]   sl, sr;
  logic [15:0]   cur_prev;
  logic [1:0]    m;

  assign s_tready = (st == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ld       = accept && (s_tuser == REQ_LOAD) && (32'(frame_index) < MAX_FRAMES);

  always_comb begin
    if (32'(keyframe_count) > MAX_FRAMES) begin
      limit = CW'(MAX_FRAMES);
    end else begin
      limit = CW'(keyframe_count);
    end
  end

  assign wi_next    = wi + CW'(1);
  assign last_frame = (wi_next >= limit);
  assign tq         = {1'b0, timer, 15'b0};
  assign m          = kf.motor;
  assign cur_prev   = prev[m];

  // steering scales in Q1.15
  always_comb begin
    if (direction <= 16'd16384) begin
      sl = 16'd32768;
    end else if (direction >= 16'd32768) begin
      sl = 16'd0;
    end else begin
      sl = 16'(17'h10000 - {direction, 1'b0});
    end
    if ({direction, 1'b0} > 17'd32768) begin
      sr = 16'd32768;
    end else begin
      sr = 16'({direction, 1'b0});
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_us      <= '0;
      amplitude      <= 16'd16384;
      direction      <= 16'd16384;
      init_pos[0]    <= '0;
      init_pos[1]    <= '0;
      init_pos[2]    <= '0;
      keyframe_count <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PERIOD:    period_us      <= cfg_wdata;
        REG_AMPLITUDE: amplitude      <= cfg_wdata[15:0];
        REG_DIRECTION: direction      <= cfg_wdata[15:0];
        REG_INIT0:     init_pos[0]    <= cfg_wdata[15:0];
        REG_INIT1:     init_pos[1]    <= cfg_wdata[15:0];
        REG_INIT2:     init_pos[2]    <= cfg_wdata[15:0];
        REG_KF_COUNT:  keyframe_count <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // keyframe table, registered read
  always_ff @(posedge clk) begin
    if (ld) begin
      mem[IW'(frame_index)] <= '{motor: frame_motor, amount: frame_amount,
                                 start: frame_start, duration: frame_duration};
    end
    if (st == FETCH) begin
      kf <= mem[wi[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= IDLE;
      timer    <= '0;
      m_tvalid <= 1'b0;
      wi       <= '0;
      bc       <= '0;
      mi       <= '0;
    end else begin
      if (m_tvalid && m_tready && (st != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        IDLE: begin
          if (accept && (s_tuser == REQ_TICK)) begin
            delta <= delta_us;
            st    <= T_ADD;
          end
        end
        T_ADD: begin
          tsum <= {1'b0, timer} + {1'b0, delta};
          st   <= T_WRAP;
        end
        T_WRAP: begin
          if (tsum >= {1'b0, period_us}) begin
            if (tsum - {1'b0, period_us} > 25'hFFFFFF) begin
              timer <= 24'hFFFFFF;
            end else begin
              timer <= 24'(tsum - {1'b0, period_us});
            end
          end else if (tsum > 25'hFFFFFF) begin
            timer <= 24'hFFFFFF;
          end else begin
            timer <= tsum[23:0];
          end
          for (int k = 0; k < 3; k++) begin
            prev[k] <= init_pos[k];
            pos[k]  <= init_pos[k];
          end
          wi <= '0;
          mi <= '0;
          st <= (limit == '0) ? D_SCALE : FETCH;
        end
        FETCH: st <= LOOK;
        LOOK: begin
          s_val <= 40'(kf.start) * 40'(period_us);
          if (m > MOTOR_RIGHT) begin
            wi <= wi_next;
            st <= last_frame ? D_SCALE : FETCH;
          end else begin
            st <= LOOK2;
          end
        end
        LOOK2: begin
          d_val <= 40'(kf.duration) * 40'(period_us);
          st    <= CMP;
        end
        CMP: begin
          ge    <= (tq >= s_val);
          n_val <= tq - s_val;
          st    <= CHK;
        end
        CHK: begin
          if (ge && (n_val < d_val)) begin
            up  <= (kf.amount >= cur_prev);
            dif <= (kf.amount >= cur_prev) ? kf.amount - cur_prev : cur_prev - kf.amount;
            mb  <= (kf.amount >= cur_prev) ? kf.amount - cur_prev : cur_prev - kf.amount;
            acc <= '0;
            bc  <= '0;
            st  <= MUL;
          end else begin
            prev[m] <= kf.amount;
            wi      <= wi_next;
            st      <= last_frame ? D_SCALE : FETCH;
          end
        end
        MUL: begin
          // one multiplier bit per cycle, msb first
          acc <= {acc[54:0], 1'b0} + (mb[15] ? 56'(n_val) : 56'd0);
          mb  <= {mb[14:0], 1'b0};
          bc  <= bc + 4'd1;
          if (bc == 4'd15) begin
            dsh <= {1'b0, d_val, 15'b0};
            bc  <= '0;
            st  <= DIV;
          end
        end
        DIV: begin
          // restoring division, quotient known to fit 16 bits
          if (acc >= dsh) begin
            acc <= acc - dsh;
            quo <= {quo[14:0], 1'b1};
          end else begin
            quo <= {quo[14:0], 1'b0};
          end
          dsh <= dsh >> 1;
          bc  <= bc + 4'd1;
          if (bc == 4'd15) begin
            st <= APPLY;
          end
        end
        APPLY: begin
          pos[m] <= up ? cur_prev + quo : cur_prev - quo;
          wi     <= wi_next;
          st     <= last_frame ? D_SCALE : FETCH;
        end
        D_SCALE: begin
          case (mi)
            MOTOR_LEFT:  sp <= 16'((32'(pos[0]) * 32'(sl)) >> 15);
            MOTOR_RIGHT: sp <= 16'((32'(pos[2]) * 32'(sr)) >> 15);
            default:     sp <= pos[1];
          endcase
          st <= D_AMP;
        end
        D_AMP: begin
          pa <= 32'(sp) * 32'(amplitude);
          st <= D_FS;
        end
        D_FS: begin
          pf <= 40'(pa) * 40'(FS);
          st <= D_SAT;
        end
        D_SAT: begin
          drv[mi] <= (pf >= FS_LIM) ? FS : pf[36:29];
          mi      <= mi + 2'd1;
          st      <= (mi == MOTOR_RIGHT) ? DONE : D_SCALE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {drv[2], drv[1], drv[0]};
            st       <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] <= FS) && (m_tdata[15:8] <= FS) && (m_tdata[23:16] <= FS))
    else $error("drive value above full scale");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (st == APPLY) |-> (quo <= dif))
    else $error("interpolation step exceeds keyframe span");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (st == FETCH) |-> (wi < limit))
    else $error("keyframe walk past table limit");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (st == DONE) && m_tvalid && !m_tready |=> (st == DONE) && !s_tready)
    else $error("result dropped while output stalled");
`endif

endmodule

FILE: tb/sv/testbench.sv
// testbench for the keyframe servo interpolator: random stream traffic checked by a predictor
`timescale 1ns / 100ps

module testbench;
  import ksi_pkg::*;

  typedef struct {
    logic        kind;
    logic [2:0]  slot;
    logic [1:0]  motor;
    logic [15:0] amount;
    logic [15:0] start;
    logic [15:0] dur;
    logic [23:0] delta;
  } servo_req_t;

  localparam int DRAIN_CYCLES = 400;
  localparam int IDLE_LIMIT   = 20000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [79:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  keyframe_servo_interpolator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [1:0]  kf_motor [8];
  logic [15:0] kf_amount [8];
  logic [15:0] kf_start [8];
  logic [15:0] kf_dur [8];
  logic [23:0] timer_us;
  logic [23:0] period_us;
  logic [15:0] gain;
  logic [15:0] steer;
  logic [15:0] home_pos [3];
  logic [3:0]  frame_count;

  servo_req_t  req_q [$];
  servo_req_t  cur_req;
  logic [23:0] drive_q [$];
  bit          taken;
  bit          hold_req;
  bit          calm;
  int          send_gap;
  int          recv_gap;
  int          hold_cnt;
  int          idle_cycles;
  int          errors;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] to_drive(longint unsigned pos);
    longint unsigned prod;
    prod = pos * gain * FULL_SCALE_DEF;
    if (prod >= (longint'(FULL_SCALE_DEF) << 29)) return 8'(FULL_SCALE_DEF);
    return 8'(prod >> 29);
  endfunction

  function automatic logic [23:0] predict_drive(logic [23:0] delta);
    longint unsigned t, tq, p, s, e, n, q, sl, sr;
    longint unsigned prev [3];
    longint unsigned pos [3];
    int cnt, m;
    p = period_us;
    t = longint'(timer_us) + delta;
    if (t >= p) t -= p;
    if (t > 24'hFFFFFF) t = 24'hFFFFFF;
    timer_us = 24'(t);
    for (int i = 0; i < 3; i++) begin
      prev[i] = home_pos[i];
      pos[i] = home_pos[i];
    end
    cnt = frame_count > 8 ? 8 : frame_count;
    tq = t << 15;
    for (int i = 0; i < cnt; i++) begin
      m = kf_motor[i];
      if (m > 2) continue;
      s = longint'(kf_start[i]) * p;
      e = (longint'(kf_start[i]) + kf_dur[i]) * p;
      if (tq < s || tq >= e) begin
        prev[m] = kf_amount[i];
      end else begin
        n = tq - s;
        if (kf_amount[i] >= prev[m]) begin
          q = ((kf_amount[i] - prev[m]) * n) / (e - s);
          pos[m] = prev[m] + q;
        end else begin
          q = ((prev[m] - kf_amount[i]) * n) / (e - s);
          pos[m] = prev[m] - q;
        end
      end
    end
    if (steer <= 16384) sl = 32768;
    else if (steer >= 32768) sl = 0;
    else sl = 65536 - 2 * longint'(steer);
    sr = 2 * longint'(steer);
    if (sr > 32768) sr = 32768;
    pos[0] = (pos[0] * sl) >> 15;
    pos[2] = (pos[2] * sr) >> 15;
    return {to_drive(pos[2]), to_drive(pos[1]), to_drive(pos[0])};
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst) begin
      if (!(s_tvalid && !taken)) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap--;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_tuser <= cur_req.kind;
          s_tdata <= {3'b0, cur_req.delta, cur_req.dur, cur_req.start, cur_req.amount,
                      cur_req.motor, cur_req.slot};
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      taken = 0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // input transfers update the predictor, output transfers are checked
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        taken = 1;
        idle_cycles = 0;
        if (cur_req.kind == REQ_LOAD) begin
          kf_motor[cur_req.slot] = cur_req.motor;
          kf_amount[cur_req.slot] = cur_req.amount;
          kf_start[cur_req.slot] = cur_req.start;
          kf_dur[cur_req.slot] = cur_req.dur;
        end else begin
          drive_q.push_back(predict_drive(cur_req.delta));
        end
      end
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          logic [23:0] want;
          want = drive_q.pop_front();
          for (int k = 0; k < 3; k++)
            if (want[k*8 +: 8] !== m_tdata[k*8 +: 8]) begin
              $display("%0t: motor %0d mismatch, expected %0d, actual %0d",
                       $time, k, want[k*8 +: 8], m_tdata[k*8 +: 8]);
              errors++;
            end
        end
      end
      if (cfg_we) idle_cycles = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PERIOD:    period_us = val;
      REG_AMPLITUDE: gain = val[15:0];
      REG_DIRECTION: steer = val[15:0];
      REG_INIT0:     home_pos[0] = val[15:0];
      REG_INIT1:     home_pos[1] = val[15:0];
      REG_INIT2:     home_pos[2] = val[15:0];
      REG_KF_COUNT:  frame_count = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (req_q.size() > 0 || s_tvalid || drive_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_load(int slot, logic [1:0] motor, int amount, int start, int dur);
    servo_req_t r;
    r.kind = REQ_LOAD;
    r.slot = 3'(slot);
    r.motor = motor;
    r.amount = 16'(amount);
    r.start = 16'(start);
    r.dur = 16'(dur);
    r.delta = 24'($urandom);
    req_q.push_back(r);
  endtask

  task automatic push_tick(int delta);
    servo_req_t r;
    r.kind = REQ_TICK;
    r.slot = 3'($urandom);
    r.motor = 2'($urandom);
    r.amount = 16'($urandom);
    r.start = 16'($urandom);
    r.dur = 16'($urandom);
    r.delta = 24'(delta);
    req_q.push_back(r);
  endtask

  task automatic random_items(int cnt);
    int r;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_load($urandom_range(0, 7),
                  $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 32768),
                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 32768),
                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 16384));
      end else if (r < 88) begin
        push_tick($urandom_range(0, period_us / 4 + 1));
      end else begin
        push_tick($urandom_range(0, 24'hFFFFFF));
      end
    end
  endtask

  initial begin
    logic [23:0] periods [6];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_LOAD;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    timer_us = '0;
    period_us = '0;
    gain = 16'd16384;
    steer = 16'd16384;
    home_pos[0] = '0;
    home_pos[1] = '0;
    home_pos[2] = '0;
    frame_count = '0;
    errors = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_cnt = 0;
    hold_req = 0;
    calm = 0;
    taken = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero period with reset defaults: outputs follow initial positions
    push_tick(0);
    push_tick(24'hFFFFFF);
    // fill every slot first so no tick reads an unloaded one
    push_load(0, MOTOR_LEFT, 0, 0, 65535);
    push_load(1, MOTOR_CENTRE, 65535, 65535, 0);
    push_load(2, MOTOR_RIGHT, 32768, 0, 32768);
    push_load(3, 2'd3, 12345, 0, 65535);
    push_load(4, MOTOR_RIGHT, 1234, 16384, 16384);
    push_load(5, MOTOR_LEFT, 32768, 8192, 8192);
    push_load(6, MOTOR_CENTRE, 0, 0, 32768);
    push_load(7, MOTOR_LEFT, 20000, 24576, 20000);
    push_tick(5);
    drain();

    // count beyond the table, steering past full right, twice the default gain
    write_reg(REG_PERIOD, 1000);
    write_reg(REG_KF_COUNT, 15);
    write_reg(REG_DIRECTION, 40000);
    write_reg(REG_AMPLITUDE, 32768);
    write_reg(REG_INIT0, 100);
    write_reg(REG_INIT1, 32768);
    write_reg(REG_INIT2, 65535);
    foreach (periods[i]) periods[i] = 0;
    push_tick(0);
    push_tick(250);
    push_tick(500);
    push_tick(999);
    push_tick(1000);
    push_tick(24'hFFFFFF);
    push_tick(300);
    drain();

    periods[0] = 20000;
    periods[1] = 1000;
    periods[2] = 24'hFFFFFF;
    periods[3] = 0;
    periods[4] = 24'($urandom_range(1, 100000));
    periods[5] = 7;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PERIOD, periods[ph]);
      write_reg(REG_AMPLITUDE, ph == 0 ? 0 : ph == 1 ? 32768 : ph == 5 ? 65535
                               : $urandom_range(0, 32768));
      write_reg(REG_DIRECTION, ph == 0 ? 0 : ph == 1 ? 32768 : ph == 2 ? 65535
                               : $urandom_range(0, 32768));
      write_reg(REG_INIT0, ph == 1 ? 32768 : $urandom_range(0, 32768));
      write_reg(REG_INIT1, ph == 0 ? 0 : $urandom_range(0, 65535));
      write_reg(REG_INIT2, $urandom_range(0, 32768));
      write_reg(REG_KF_COUNT, ph == 3 ? 0 : ph == 2 ? 8 : $urandom_range(1, 15));
      calm = (ph == 4);
      if (ph == 1) begin
        @(posedge clk);
        hold_req = 1;
      end
      random_items(135);
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
